FILE: hdl/nearest_palette_color_match_defines.svh
// Assertion helpers for the palette matcher
`ifndef NEAREST_PALETTE_COLOR_MATCH_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_MATCH_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define NPCM_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("npcm check failed");

// Next-cycle implication, disabled during reset
`define NPCM_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("npcm check failed");

`endif

FILE: hdl/npcm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npcm_pkg
// Shared types and codes for the palette colour matcher.
// ----------------------------------------------------------------------------
package npcm_pkg;

    // Item operation codes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_MATCH = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Configuration register indexes
    localparam logic REG_COUNT     = 1'b0;
    localparam logic REG_NO_REPEAT = 1'b1;

    localparam int unsigned IDX_W  = 12;
    localparam int unsigned DIST_W = 9;
    localparam int unsigned CNT_W  = 13;

    // Controller to datapath commands
    typedef struct packed {
        logic pal_wr;   // write palette entry from input beat
        logic start;    // latch query pixel, clear best
        logic issue;    // read entry at scan address
        logic clr_wr;   // clear one used mark at sweep address
        logic mark;     // mark winner used (no-repeat only)
        logic load;     // move result into output register
    } t_cmd;

    // Datapath status
    typedef struct packed {
        logic busy;     // scan pipeline holds live entries
        logic out_free; // output register can take a result
    } t_sts;

endpackage

FILE: hdl/npcm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npcm_in_if / npcm_out_if
// Valid/ready channels for item beats and result beats.
// ----------------------------------------------------------------------------
interface npcm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [11:0] entry_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    modport source (output valid, operation, entry_index, red, green, blue, input ready);
    modport sink   (input valid, operation, entry_index, red, green, blue, output ready);
endinterface

interface npcm_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] match_index;
    logic [8:0]  match_distance;
    logic        none_free;
    modport source (output valid, match_index, match_distance, none_free, input ready);
    modport sink   (input valid, match_index, match_distance, none_free, output ready);
endinterface

FILE: hdl/npcm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npcm_ctrl
// Sequencer: used-mark sweep, palette scan issue, mark and result hand-off.
// ----------------------------------------------------------------------------
`include "nearest_palette_color_match_defines.svh"
module npcm_ctrl
    import npcm_pkg::*;
#(
    parameter int unsigned PALETTE_DEPTH = 4096,
    parameter int unsigned AW = 12,
    parameter int unsigned CW = 13
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_op,
    input  logic [CNT_W-1:0]   i_palette_count,
    output t_cmd               o_cmd,
    output logic [AW-1:0]      o_addr,
    input  t_sts               i_sts
);

    typedef enum logic [2:0] {
        S_CLR, S_IDLE, S_SCAN, S_DRAIN, S_MARK, S_OUT
    } t_state;

    t_state          r_state;
    logic [CW-1:0]   r_cnt;
    logic [CW-1:0]   r_lim;
    logic [CW-1:0]   w_lim;
    logic            w_acc;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_acc      = i_in_valid && o_in_ready;
    assign o_addr     = r_cnt[AW-1:0];

    // active entries, saturated to the store depth
    assign w_lim = (32'(i_palette_count) > 32'(PALETTE_DEPTH)) ? CW'(PALETTE_DEPTH)
                                                             : CW'(i_palette_count);

    // commands
    always_comb begin
        o_cmd        = '0;
        o_cmd.pal_wr = w_acc && (i_op == OP_WRITE);
        o_cmd.start  = w_acc && (i_op == OP_MATCH);
        o_cmd.issue  = (r_state == S_SCAN);
        o_cmd.clr_wr = (r_state == S_CLR);
        o_cmd.mark   = (r_state == S_MARK);
        o_cmd.load   = (r_state == S_OUT) && i_sts.out_free;
    end

    // state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_cnt   <= '0;
            r_lim   <= '0;
        end else begin
            case (r_state)
                S_CLR: begin
                    if (r_cnt == CW'(PALETTE_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                        r_cnt   <= '0;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (w_acc && i_op == OP_CLEAR) begin
                        r_state <= S_CLR;
                        r_cnt   <= '0;
                    end else if (w_acc && i_op == OP_MATCH) begin
                        r_lim   <= w_lim;
                        r_cnt   <= '0;
                        r_state <= (w_lim == '0) ? S_MARK : S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_cnt == r_lim - 1'b1) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DRAIN: begin
                    if (!i_sts.busy) r_state <= S_MARK;
                end
                S_MARK: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_sts.out_free) r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // checks
    `NPCM_ASSERT_IMP(a_idle_quiet, i_clk, i_rst_n, r_state == S_IDLE, !i_sts.busy)
    `NPCM_ASSERT_NXT(a_load_idle, i_clk, i_rst_n, o_cmd.load, r_state == S_IDLE)
    `NPCM_ASSERT_IMP(a_scan_range, i_clk, i_rst_n, r_state == S_SCAN, r_cnt < r_lim)

endmodule

FILE: hdl/npcm_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npcm_dpath
// Palette and used-mark stores, distance and square-root pipeline, best
// tracker and output register.
// ----------------------------------------------------------------------------
module npcm_dpath
    import npcm_pkg::*;
#(
    parameter int unsigned PALETTE_DEPTH = 4096,
    parameter int unsigned AW = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic [AW-1:0]      i_addr,
    input  logic               i_no_repeat,
    input  logic [IDX_W-1:0]   i_entry_index,
    input  logic [7:0]         i_red,
    input  logic [7:0]         i_green,
    input  logic [7:0]         i_blue,
    output t_sts               o_sts,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [IDX_W-1:0]   o_match_index,
    output logic [DIST_W-1:0]  o_match_distance,
    output logic               o_none_free
);

    localparam int unsigned NS = DIST_W; // one root bit per stage

    logic [23:0]        r_pal [PALETTE_DEPTH];
    logic               r_used [PALETTE_DEPTH];
    logic [23:0]        r_pix;

    // read stage
    logic               r_rd_v;
    logic [AW-1:0]      r_rd_idx;
    logic [23:0]        r_pal_q;
    logic               r_used_q;

    // square stage
    logic               r_sq_v;
    logic [AW-1:0]      r_sq_idx;
    logic [15:0]        r_sq_r, r_sq_g, r_sq_b;

    // sum stage
    logic               r_sum_v;
    logic [AW-1:0]      r_sum_idx;
    logic [17:0]        r_sum;

    // root stages
    logic               r_sr_v    [NS];
    logic [AW-1:0]      r_sr_idx  [NS];
    logic [19:0]        r_sr_rem  [NS];
    logic [19:0]        r_sr_root [NS];

    // best tracker and output
    logic               r_found;
    logic [AW-1:0]      r_best_idx;
    logic [DIST_W-1:0]  r_best_dist;
    logic               r_out_v;
    logic [IDX_W-1:0]   r_out_idx;
    logic [DIST_W-1:0]  r_out_dist;
    logic               r_out_nf;

    logic               w_busy;
    logic [DIST_W-1:0]  w_root;

    function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
        absdiff = (a >= b) ? (a - b) : (b - a);
    endfunction

    // palette store
    always_ff @(posedge i_clk) begin
        if (i_cmd.pal_wr && (32'(i_entry_index) < 32'(PALETTE_DEPTH)))
            r_pal[AW'(i_entry_index)] <= {i_red, i_green, i_blue};
        r_pal_q <= r_pal[i_addr];
    end

    // used marks: sweep clear or winner mark, one write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr)
            r_used[i_addr] <= 1'b0;
        else if (i_cmd.mark && i_no_repeat)
            r_used[r_best_idx] <= 1'b1;
        r_used_q <= r_used[i_addr];
    end

    // query pixel
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) r_pix <= {i_red, i_green, i_blue};
    end

    // distance pipeline payload
    always_ff @(posedge i_clk) begin
        r_rd_idx  <= i_addr;
        r_sq_idx  <= r_rd_idx;
        r_sq_r    <= 16'(absdiff(r_pal_q[23:16], r_pix[23:16]))
                     * 16'(absdiff(r_pal_q[23:16], r_pix[23:16]));
        r_sq_g    <= 16'(absdiff(r_pal_q[15:8], r_pix[15:8]))
                     * 16'(absdiff(r_pal_q[15:8], r_pix[15:8]));
        r_sq_b    <= 16'(absdiff(r_pal_q[7:0], r_pix[7:0]))
                     * 16'(absdiff(r_pal_q[7:0], r_pix[7:0]));
        r_sum_idx <= r_sq_idx;
        r_sum     <= 18'(r_sq_r) + 18'(r_sq_g) + 18'(r_sq_b);
    end

    // square root, one result bit per stage
    always_ff @(posedge i_clk) begin
        logic [19:0] v;
        logic [19:0] rt;
        logic [19:0] bt;
        for (int k = 0; k < NS; k++) begin
            v  = (k == 0) ? 20'(r_sum) : r_sr_rem[(k == 0) ? 0 : k - 1];
            rt = (k == 0) ? 20'd0 : r_sr_root[(k == 0) ? 0 : k - 1];
            bt = 20'd1 << (2 * (NS - 1 - k));
            if (v >= rt + bt) begin
                r_sr_rem[k]  <= v - (rt + bt);
                r_sr_root[k] <= (rt >> 1) + bt;
            end else begin
                r_sr_rem[k]  <= v;
                r_sr_root[k] <= rt >> 1;
            end
            r_sr_idx[k] <= (k == 0) ? r_sum_idx : r_sr_idx[(k == 0) ? 0 : k - 1];
        end
    end

    assign w_root = r_sr_root[NS-1][DIST_W-1:0];

    // stage valids; used entries drop out in no-repeat mode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v  <= 1'b0;
            r_sq_v  <= 1'b0;
            r_sum_v <= 1'b0;
            for (int k = 0; k < NS; k++) r_sr_v[k] <= 1'b0;
        end else begin
            r_rd_v  <= i_cmd.issue;
            r_sq_v  <= r_rd_v && !(i_no_repeat && r_used_q);
            r_sum_v <= r_sq_v;
            r_sr_v[0] <= r_sum_v;
            for (int k = 1; k < NS; k++) r_sr_v[k] <= r_sr_v[k-1];
        end
    end

    // first strictly smaller distance wins
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found     <= 1'b0;
            r_best_idx  <= '0;
            r_best_dist <= '0;
        end else if (i_cmd.start) begin
            r_found     <= 1'b0;
            r_best_idx  <= '0;
            r_best_dist <= '0;
        end else if (r_sr_v[NS-1] && (!r_found || w_root < r_best_dist)) begin
            r_found     <= 1'b1;
            r_best_idx  <= r_sr_idx[NS-1];
            r_best_dist <= w_root;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_v <= 1'b1;
        end else if (i_ready) begin
            r_out_v <= 1'b0;
        end
        if (i_cmd.load) begin
            r_out_idx  <= IDX_W'(r_best_idx);
            r_out_dist <= r_best_dist;
            r_out_nf   <= !r_found;
        end
    end

    always_comb begin
        w_busy = r_rd_v || r_sq_v || r_sum_v;
        for (int k = 0; k < NS; k++) w_busy = w_busy || r_sr_v[k];
    end

    assign o_sts.busy       = w_busy;
    assign o_sts.out_free   = !r_out_v || i_ready;
    assign o_valid          = r_out_v;
    assign o_match_index    = r_out_idx;
    assign o_match_distance = r_out_dist;
    assign o_none_free      = r_out_nf;

endmodule

FILE: hdl/nearest_palette_color_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_palette_color_match
// Nearest palette colour search with optional no-repeat marking.
// ----------------------------------------------------------------------------
// A palette write is stored as the item is taken; a clear item runs a sweep over
// the used marks of all PALETTE_DEPTH entries, and the same sweep runs once after
// reset, with no item taken meanwhile (register writes still land). A match reads
// one palette entry per cycle from the single read port of the palette memory,
// then waits for the 12-stage distance and square-root pipeline to drain, passes
// a mark state (the winner is marked in no-repeat mode) and hands off the result.
// Items are worked one at a time.
module nearest_palette_color_match
    import npcm_pkg::*;
#(
    parameter int unsigned PALETTE_DEPTH = 4096
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    npcm_in_if.sink      i_in,
    npcm_out_if.source   o_out,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int unsigned AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(PALETTE_DEPTH + 1);

    logic [CNT_W-1:0] r_palette_count;
    logic             r_no_repeat;
    logic             w_wr;
    t_cmd             w_cmd;
    t_sts             w_sts;
    logic [AW-1:0]    w_addr;

    // configuration registers
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_palette_count <= '0;
            r_no_repeat     <= 1'b0;
        end else if (w_wr) begin
            if (paddr[2] == REG_COUNT) r_palette_count <= pwdata[CNT_W-1:0];
            else                       r_no_repeat     <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == REG_NO_REPEAT) ? {31'd0, r_no_repeat}
                                                : {19'd0, r_palette_count};

    npcm_ctrl #(
        .PALETTE_DEPTH (PALETTE_DEPTH),
        .AW            (AW),
        .CW            (CW)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in.valid),
        .o_in_ready      (i_in.ready),
        .i_op            (i_in.operation),
        .i_palette_count (r_palette_count),
        .o_cmd           (w_cmd),
        .o_addr          (w_addr),
        .i_sts           (w_sts)
    );

    npcm_dpath #(
        .PALETTE_DEPTH (PALETTE_DEPTH),
        .AW            (AW)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_addr           (w_addr),
        .i_no_repeat      (r_no_repeat),
        .i_entry_index    (i_in.entry_index),
        .i_red            (i_in.red),
        .i_green          (i_in.green),
        .i_blue           (i_in.blue),
        .o_sts            (w_sts),
        .o_valid          (o_out.valid),
        .i_ready          (o_out.ready),
        .o_match_index    (o_out.match_index),
        .o_match_distance (o_out.match_distance),
        .o_none_free      (o_out.none_free)
    );

endmodule
